// File: src/srmt_pkg.sv
`timescale 1ns / 1ps

package srmt_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W        = 16;
  localparam int TOTAL_W      = 7;

  // Operation codes.
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  // Status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;
  localparam logic [1:0] STATUS_DUPLICATE = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] member_key;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               has_neighbors;
    logic [KEY_W-1:0]   left_neighbor;
    logic [KEY_W-1:0]   right_neighbor;
    logic [TOTAL_W-1:0] member_total;
  } out_word_t;

endpackage

// File: src/srmt_ram.sv
`timescale 1ns / 1ps

module srmt_ram #(
  parameter int DEPTH = srmt_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic [AW-1:0]              raddr,
  output logic [srmt_pkg::KEY_W-1:0] rdata,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [srmt_pkg::KEY_W-1:0] wdata
);

  logic [srmt_pkg::KEY_W-1:0] mem [DEPTH];
  logic [srmt_pkg::KEY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/srmt_engine.sv
`timescale 1ns / 1ps

module srmt_engine #(
  parameter int CAPACITY = srmt_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srmt_pkg::in_word_t  in_word,
  output logic                res_valid,
  input  logic                res_ready,
  output srmt_pkg::out_word_t res_word
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int KW = srmt_pkg::KEY_W;
  localparam int TW = srmt_pkg::TOTAL_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_SHIFT_UP, ST_SHIFT_DOWN, ST_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       lt_cnt_r, lt_cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       wa_r, wa_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic [KW-1:0]       key_r, key_nxt;
  logic [KW-1:0]       first_r, first_nxt;
  logic [KW-1:0]       last_r, last_nxt;
  logic [KW-1:0]       pred_r, pred_nxt;
  logic [KW-1:0]       succ_r, succ_nxt;
  logic                seen_r, seen_nxt;
  logic                has_pred_r, has_pred_nxt;
  logic                has_succ_r, has_succ_nxt;
  logic                found_r, found_nxt;
  srmt_pkg::out_word_t res_r, res_nxt;

  logic [CW-1:0] idx_inc, idx_dec;
  logic [KW-1:0] left_v, right_v;
  logic [AW-1:0] ram_raddr, ram_waddr;
  logic [KW-1:0] ram_rdata, ram_wdata;
  logic          ram_we;

  srmt_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
    .clk   (clk),
    .raddr (ram_raddr),
    .rdata (ram_rdata),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata)
  );

  assign idx_inc   = idx_r + CW'(1);
  assign idx_dec   = idx_r - CW'(1);
  assign left_v    = has_pred_r ? pred_r : last_r;
  assign right_v   = has_succ_r ? succ_r : first_r;
  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res_word  = res_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    lt_cnt_nxt   = lt_cnt_r;
    pend_nxt     = 1'b0;
    wa_nxt       = wa_r;
    mode_nxt     = mode_r;
    key_nxt      = key_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    pred_nxt     = pred_r;
    succ_nxt     = succ_r;
    seen_nxt     = seen_r;
    has_pred_nxt = has_pred_r;
    has_succ_nxt = has_succ_r;
    found_nxt    = found_r;
    res_nxt      = res_r;
    ram_raddr    = idx_r[AW-1:0];
    ram_we       = 1'b0;
    ram_waddr    = wa_r;
    ram_wdata    = ram_rdata;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt     = in_word.mode;
          key_nxt      = in_word.member_key;
          idx_nxt      = '0;
          lt_cnt_nxt   = '0;
          seen_nxt     = 1'b0;
          has_pred_nxt = 1'b0;
          has_succ_nxt = 1'b0;
          found_nxt    = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Every member is read once; the word arriving now is the next in order.
        if (pend_r) begin
          if (!seen_r) begin
            first_nxt = ram_rdata;
          end
          seen_nxt = 1'b1;
          last_nxt = ram_rdata;
          if (ram_rdata < key_r) begin
            pred_nxt     = ram_rdata;
            has_pred_nxt = 1'b1;
            lt_cnt_nxt   = lt_cnt_r + CW'(1);
          end else if (ram_rdata == key_r) begin
            found_nxt = 1'b1;
          end else if (!has_succ_r) begin
            succ_nxt     = ram_rdata;
            has_succ_nxt = 1'b1;
          end
        end
        if (idx_r < cnt_r) begin
          ram_raddr = idx_r[AW-1:0];
          idx_nxt   = idx_inc;
          pend_nxt  = 1'b1;
        end else if (!pend_r) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        res_nxt.status         = srmt_pkg::STATUS_OK;
        res_nxt.has_neighbors  = 1'b0;
        res_nxt.left_neighbor  = '0;
        res_nxt.right_neighbor = '0;
        res_nxt.member_total   = TW'(cnt_r);
        state_nxt              = ST_DONE;
        case (mode_r)
          srmt_pkg::MODE_INSERT: begin
            if (found_r) begin
              res_nxt.status = srmt_pkg::STATUS_DUPLICATE;
            end else if (cnt_r == CW'(CAPACITY)) begin
              res_nxt.status = srmt_pkg::STATUS_FULL;
            end else begin
              // Neighbors among the old members are the new key's ring neighbors.
              if (cnt_r != '0) begin
                res_nxt.has_neighbors  = 1'b1;
                res_nxt.left_neighbor  = left_v;
                res_nxt.right_neighbor = right_v;
              end
              res_nxt.member_total = TW'(cnt_r + CW'(1));
              idx_nxt              = cnt_r;
              state_nxt            = ST_SHIFT_UP;
            end
          end
          srmt_pkg::MODE_DELETE: begin
            if (!found_r) begin
              res_nxt.status = srmt_pkg::STATUS_NOT_FOUND;
            end else begin
              res_nxt.member_total = TW'(cnt_r - CW'(1));
              idx_nxt              = lt_cnt_r + CW'(1);
              state_nxt            = ST_SHIFT_DOWN;
            end
          end
          default: begin
            if (!found_r) begin
              res_nxt.status = srmt_pkg::STATUS_NOT_FOUND;
            end else if (cnt_r > CW'(1)) begin
              res_nxt.has_neighbors  = 1'b1;
              res_nxt.left_neighbor  = left_v;
              res_nxt.right_neighbor = right_v;
            end
          end
        endcase
      end

      ST_SHIFT_UP: begin
        // Move entries from the top down to the insert position up by one.
        if (pend_r) begin
          ram_we = 1'b1;
        end
        if (idx_r > lt_cnt_r) begin
          ram_raddr = idx_dec[AW-1:0];
          wa_nxt    = idx_r[AW-1:0];
          idx_nxt   = idx_dec;
          pend_nxt  = 1'b1;
        end else if (!pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = lt_cnt_r[AW-1:0];
          ram_wdata = key_r;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = ST_DONE;
        end
      end

      ST_SHIFT_DOWN: begin
        // Close the gap left by the deleted key.
        if (pend_r) begin
          ram_we = 1'b1;
        end
        if (idx_r < cnt_r) begin
          ram_raddr = idx_r[AW-1:0];
          wa_nxt    = idx_dec[AW-1:0];
          idx_nxt   = idx_inc;
          pend_nxt  = 1'b1;
        end else if (!pend_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
    idx_r      <= idx_nxt;
    lt_cnt_r   <= lt_cnt_nxt;
    wa_r       <= wa_nxt;
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    pred_r     <= pred_nxt;
    succ_r     <= succ_nxt;
    seen_r     <= seen_nxt;
    has_pred_r <= has_pred_nxt;
    has_succ_r <= has_succ_nxt;
    found_r    <= found_nxt;
    res_r      <= res_nxt;
  end

endmodule

// File: src/sorted_ring_membership_table.sv
`timescale 1ns / 1ps
// Channel  | Ports                          | Word
// ---------+--------------------------------+-----------------------------------
// input    | in_valid, in_ready, in_word    | mode, member_key
// result   | out_valid, out_ready, out_word | status, neighbors, member_total
//
// One word is in work at a time. A word first scans the N stored members
// through the single-port read of the key memory; a successful insert or
// delete then shifts entries one per cycle before the result is handed over.
// Reset (rst_n low, synchronous) empties the table; the memory is not cleared.
// A result waiting in the output register does not stop the next word from
// being accepted and worked on; only its hand-over waits for the register.

module sorted_ring_membership_table #(
  parameter int CAPACITY = srmt_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srmt_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output srmt_pkg::out_word_t out_word
);

  logic                res_valid;
  logic                res_ready;
  srmt_pkg::out_word_t res_word;

  logic                out_valid_r, out_valid_nxt;
  srmt_pkg::out_word_t out_word_r, out_word_nxt;
  logic                load;

  // The engine owns the key memory, the member count and the sequencing of
  // scan and shift passes.
  srmt_engine #(.CAPACITY(CAPACITY)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

  // The output register takes a new result when it is empty or being emptied.
  assign res_ready = !out_valid_r || out_ready;
  assign load      = res_valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef ASSERT_OFF
  // A word just accepted keeps the engine busy for at least the next cycle.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again right after an accept");

  // The engine never offers a result while it is open for a new word.
  a_idle_no_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !res_valid)
    else $error("result offered while idle");

  // Neighbors are reported only on a successful operation.
  a_neighbors_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.has_neighbors |-> out_word.status == srmt_pkg::STATUS_OK)
    else $error("neighbors reported with an error status");

  // The reported count never exceeds the capacity (checked for capacities up to 127).
  a_total_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CAPACITY > 127) ||
                  (out_word.member_total <= srmt_pkg::TOTAL_W'(CAPACITY)))
    else $error("member total above capacity");
`endif

endmodule
